### rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// mi3_pkg: shared constants for the 3x3 matrix inverse core
// no dependencies; imported by mi3_cofactor and matrix3x3_inverse_core
package mi3_pkg;

  localparam int unsigned MI3_ELEMS = 9;
  localparam int unsigned MI3_ROWS  = 3;

  // operand indices of each adjugate entry: a*b - c*d, elements in row-major order
  localparam int unsigned MI3_MINOR_IDX [MI3_ELEMS][4] = '{
    '{4, 8, 7, 5},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // cofactors of the first row, used for the determinant expansion
  localparam int unsigned MI3_ROW0_COF [MI3_ROWS] = '{0, 3, 6};

endpackage

### rtl/mi3_in_if.sv
`timescale 1ns / 1ps
// mi3_in_if: input transaction channel carrying one 3x3 matrix
// no dependencies
interface mi3_in_if #(
  parameter int unsigned ELEMENT_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] in_r0c0;
  logic signed [ELEMENT_WIDTH-1:0] in_r0c1;
  logic signed [ELEMENT_WIDTH-1:0] in_r0c2;
  logic signed [ELEMENT_WIDTH-1:0] in_r1c0;
  logic signed [ELEMENT_WIDTH-1:0] in_r1c1;
  logic signed [ELEMENT_WIDTH-1:0] in_r1c2;
  logic signed [ELEMENT_WIDTH-1:0] in_r2c0;
  logic signed [ELEMENT_WIDTH-1:0] in_r2c1;
  logic signed [ELEMENT_WIDTH-1:0] in_r2c2;

  modport source (
    output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    input  ready
  );
  modport sink (
    input  valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
           in_r2c0, in_r2c1, in_r2c2,
    output ready
  );
endinterface

### rtl/mi3_out_if.sv
`timescale 1ns / 1ps
// mi3_out_if: result transaction channel carrying inverse, determinant and flags
// no dependencies
interface mi3_out_if #(
  parameter int unsigned ELEMENT_WIDTH = 32
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] out_r0c0;
  logic signed [ELEMENT_WIDTH-1:0] out_r0c1;
  logic signed [ELEMENT_WIDTH-1:0] out_r0c2;
  logic signed [ELEMENT_WIDTH-1:0] out_r1c0;
  logic signed [ELEMENT_WIDTH-1:0] out_r1c1;
  logic signed [ELEMENT_WIDTH-1:0] out_r1c2;
  logic signed [ELEMENT_WIDTH-1:0] out_r2c0;
  logic signed [ELEMENT_WIDTH-1:0] out_r2c1;
  logic signed [ELEMENT_WIDTH-1:0] out_r2c2;
  logic signed [ELEMENT_WIDTH-1:0] determinant;
  logic                            singular;
  logic                            saturated;

  modport source (
    output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, determinant, singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
           out_r2c0, out_r2c1, out_r2c2, determinant, singular, saturated,
    output ready
  );
endinterface

### rtl/mi3_cofactor.sv
`timescale 1ns / 1ps
// mi3_cofactor: five-stage pipeline forming the exact adjugate and determinant
// depends on mi3_pkg
module mi3_cofactor #(
  parameter int unsigned W  = 32,
  parameter int unsigned AW = 2 * W + 1,
  parameter int unsigned DW = 3 * W + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  elem_i [mi3_pkg::MI3_ELEMS],
  output logic signed [AW-1:0] adj_o  [mi3_pkg::MI3_ELEMS],
  output logic signed [DW-1:0] det_o
);
  import mi3_pkg::*;

  localparam int unsigned PW = 2 * W;
  localparam int unsigned HW = 2 * W + 1;

  logic signed [PW-1:0] prod1_r [2 * MI3_ELEMS];
  logic signed [W-1:0]  erow1_r [MI3_ROWS];
  logic signed [W-1:0]  erow2_r [MI3_ROWS];
  logic signed [AW-1:0] adj2_r  [MI3_ELEMS];
  logic signed [AW-1:0] adj3_r  [MI3_ELEMS];
  logic signed [AW-1:0] adj4_r  [MI3_ELEMS];
  logic signed [AW-1:0] adj5_r  [MI3_ELEMS];
  logic signed [HW-1:0] pl3_r   [MI3_ROWS];
  logic signed [HW-1:0] ph3_r   [MI3_ROWS];
  logic signed [DW-1:0] term4_r [MI3_ROWS];
  logic signed [DW-1:0] det5_r;
  logic signed [DW-1:0] det_nxt;

  // stage 1: eighteen element products
  for (genvar m = 0; m < MI3_ELEMS; m++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        prod1_r[2*m]   <= PW'(elem_i[MI3_MINOR_IDX[m][0]]) * PW'(elem_i[MI3_MINOR_IDX[m][1]]);
        prod1_r[2*m+1] <= PW'(elem_i[MI3_MINOR_IDX[m][2]]) * PW'(elem_i[MI3_MINOR_IDX[m][3]]);
      end
    end
  end

  // stage 2: minors; stages 3 to 5 carry them along
  for (genvar m = 0; m < MI3_ELEMS; m++) begin : g_adj
    always_ff @(posedge clk) begin
      if (en) begin
        adj2_r[m] <= AW'(prod1_r[2*m]) - AW'(prod1_r[2*m+1]);
        adj3_r[m] <= adj2_r[m];
        adj4_r[m] <= adj3_r[m];
        adj5_r[m] <= adj4_r[m];
      end
    end
  end

  // stage 3: first-row element times cofactor, split into low and high halves
  // stage 4: recombine halves
  for (genvar j = 0; j < MI3_ROWS; j++) begin : g_row0
    always_ff @(posedge clk) begin
      if (en) begin
        erow1_r[j] <= elem_i[j];
        erow2_r[j] <= erow1_r[j];
        pl3_r[j]   <= HW'(erow2_r[j]) *
                      HW'($signed({1'b0, adj2_r[MI3_ROW0_COF[j]][W-1:0]}));
        ph3_r[j]   <= HW'(erow2_r[j]) * HW'($signed(adj2_r[MI3_ROW0_COF[j]][AW-1:W]));
        term4_r[j] <= (DW'(ph3_r[j]) <<< W) + DW'(pl3_r[j]);
      end
    end
  end

  // stage 5: determinant sum
  assign det_nxt = term4_r[0] + term4_r[1] + term4_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      det5_r <= det_nxt;
    end
  end

  assign adj_o = adj5_r;
  assign det_o = det5_r;

endmodule

### rtl/mi3_div.sv
`timescale 1ns / 1ps
// mi3_div: pipelined restoring divider, one quotient bit per stage,
// with round to nearest (ties away from zero) and saturation; no dependencies
module mi3_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned NW = 97,
  parameter int unsigned DW = 98
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       num_i,
  input  logic [DW-1:0]       den_i,
  input  logic                neg_i,
  output logic signed [W-1:0] quo_o,
  output logic                clip_o
);

  localparam int unsigned XW = ((NW > DW + W) ? NW : DW + W) + 1;

  logic [XW-1:0] rem_r [W+1];
  logic [DW-1:0] den_r [W+1];
  logic [W-1:0]  quo_r [W+1];
  logic          neg_r [W+1];
  logic          ovf_r [W+1];

  logic [W:0]    mag_nxt;
  logic          up_nxt;
  logic [W-1:0]  res_nxt;
  logic          clip_nxt;
  logic [W-1:0]  res_r;
  logic          clip_r;

  // entry stage: quotient of 2^W or more saturates regardless of sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= XW'(num_i);
      den_r[0] <= den_i;
      quo_r[0] <= '0;
      neg_r[0] <= neg_i;
      ovf_r[0] <= XW'(num_i) >= (XW'(den_i) << W);
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int unsigned K = W - s;
    logic [XW-1:0] sub_nxt;
    logic          take_nxt;

    assign sub_nxt  = XW'(den_r[s-1]) << K;
    assign take_nxt = rem_r[s-1] >= sub_nxt;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take_nxt ? (rem_r[s-1] - sub_nxt) : rem_r[s-1];
        quo_r[s] <= quo_r[s-1] | (W'(take_nxt) << K);
        den_r[s] <= den_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  // rounding and saturation
  always_comb begin
    up_nxt   = {rem_r[W], 1'b0} >= (XW + 1)'(den_r[W]);
    mag_nxt  = {1'b0, quo_r[W]} + (W + 1)'(up_nxt);
    clip_nxt = 1'b0;
    res_nxt  = mag_nxt[W-1:0];
    if (neg_r[W]) begin
      if (ovf_r[W] || (mag_nxt > {2'b01, {(W-1){1'b0}}})) begin
        clip_nxt = 1'b1;
        res_nxt  = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_nxt  = ~mag_nxt[W-1:0] + W'(1);
      end
    end else if (ovf_r[W] || (mag_nxt > {2'b00, {(W-1){1'b1}}})) begin
      clip_nxt = 1'b1;
      res_nxt  = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign quo_o  = $signed(res_r);
  assign clip_o = clip_r;

endmodule

### rtl/matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
// matrix3x3_inverse_core: 3x3 inverse via adjugate and determinant, signed fixed point
// one matrix accepted per cycle while the output register is not held
// the nine dividers retire one quotient bit per stage, which sets the pipeline depth
// synchronous active-low reset clears the valid bits only; data registers are not reset
// depends on mi3_pkg, mi3_in_if, mi3_out_if, mi3_cofactor and mi3_div
module matrix3x3_inverse_core #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mi3_in_if.sink     in_ch,
  mi3_out_if.source  out_ch
);
  import mi3_pkg::*;

  localparam int unsigned W  = ELEMENT_WIDTH;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned AW = 2 * W + 1;   // adjugate entry, signed
  localparam int unsigned DW = 3 * W + 2;   // determinant, signed
  localparam int unsigned NW = AW + 2 * F;  // scaled adjugate magnitude
  localparam int unsigned DIV_STAGES = W + 2;
  localparam int unsigned DEPTH = 5 + 1 + DIV_STAGES;

  // pipeline control: whole pipe advances unless the output register is held
  logic             pipe_en;
  logic [DEPTH-1:0] vld_r;

  logic signed [W-1:0]  elem   [MI3_ELEMS];
  logic signed [AW-1:0] adj    [MI3_ELEMS];
  logic signed [DW-1:0] det;

  // magnitude/sign stage
  logic [AW-1:0] amag_r [MI3_ELEMS];
  logic          aneg_r [MI3_ELEMS];
  logic [DW-1:0] dmag_r;
  logic          dneg_r;
  logic          dzero_r;

  // determinant output path, aligned with the divider stages
  logic [DW-1:0]        drnd_nxt;
  logic [W-1:0]         dval_nxt;
  logic                 dclip_nxt;
  logic signed [W-1:0]  dval_r  [DIV_STAGES];
  logic                 dclip_r [DIV_STAGES];
  logic                 sing_r  [DIV_STAGES];

  logic signed [W-1:0]  quo  [MI3_ELEMS];
  logic [MI3_ELEMS-1:0] clip;

  assign pipe_en     = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  assign elem[0] = in_ch.in_r0c0;
  assign elem[1] = in_ch.in_r0c1;
  assign elem[2] = in_ch.in_r0c2;
  assign elem[3] = in_ch.in_r1c0;
  assign elem[4] = in_ch.in_r1c1;
  assign elem[5] = in_ch.in_r1c2;
  assign elem[6] = in_ch.in_r2c0;
  assign elem[7] = in_ch.in_r2c1;
  assign elem[8] = in_ch.in_r2c2;

  // stages 1 to 5: products, minors, determinant
  mi3_cofactor #(
    .W  (W),
    .AW (AW),
    .DW (DW)
  ) u_cofactor (
    .clk    (clk),
    .en     (pipe_en),
    .elem_i (elem),
    .adj_o  (adj),
    .det_o  (det)
  );

  // stage 6: split into sign and magnitude for the dividers
  for (genvar i = 0; i < MI3_ELEMS; i++) begin : g_abs
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        aneg_r[i] <= adj[i][AW-1];
        amag_r[i] <= adj[i][AW-1] ? (~adj[i] + AW'(1)) : adj[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dneg_r  <= det[DW-1];
      dmag_r  <= det[DW-1] ? (~det + DW'(1)) : det;
      dzero_r <= (det == '0);
    end
  end

  // determinant field: drop 2F fraction bits, round half away from zero, saturate
  always_comb begin
    drnd_nxt  = (dmag_r + (DW'(1) << (2 * F - 1))) >> (2 * F);
    dclip_nxt = 1'b0;
    dval_nxt  = drnd_nxt[W-1:0];
    if (dneg_r) begin
      if (drnd_nxt > DW'({1'b1, {(W-1){1'b0}}})) begin
        dclip_nxt = 1'b1;
        dval_nxt  = {1'b1, {(W-1){1'b0}}};
      end else begin
        dval_nxt  = ~drnd_nxt[W-1:0] + W'(1);
      end
    end else if (drnd_nxt > DW'({1'b0, {(W-1){1'b1}}})) begin
      dclip_nxt = 1'b1;
      dval_nxt  = {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dval_r[0]  <= $signed(dval_nxt);
      dclip_r[0] <= dclip_nxt;
      sing_r[0]  <= dzero_r;
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_dline
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dval_r[s]  <= dval_r[s-1];
        dclip_r[s] <= dclip_r[s-1];
        sing_r[s]  <= sing_r[s-1];
      end
    end
  end

  // nine parallel dividers: adj * 2^(2F) / det
  for (genvar i = 0; i < MI3_ELEMS; i++) begin : g_div
    mi3_div #(
      .W  (W),
      .NW (NW),
      .DW (DW)
    ) u_div (
      .clk    (clk),
      .en     (pipe_en),
      .num_i  ({amag_r[i], {(2 * F){1'b0}}}),
      .den_i  (dmag_r),
      .neg_i  (aneg_r[i] ^ dneg_r),
      .quo_o  (quo[i]),
      .clip_o (clip[i])
    );
  end

  // output register is the last divider stage; singular transactions read as zero
  assign out_ch.valid       = vld_r[DEPTH-1];
  assign out_ch.singular    = sing_r[DIV_STAGES-1];
  assign out_ch.out_r0c0    = sing_r[DIV_STAGES-1] ? '0 : quo[0];
  assign out_ch.out_r0c1    = sing_r[DIV_STAGES-1] ? '0 : quo[1];
  assign out_ch.out_r0c2    = sing_r[DIV_STAGES-1] ? '0 : quo[2];
  assign out_ch.out_r1c0    = sing_r[DIV_STAGES-1] ? '0 : quo[3];
  assign out_ch.out_r1c1    = sing_r[DIV_STAGES-1] ? '0 : quo[4];
  assign out_ch.out_r1c2    = sing_r[DIV_STAGES-1] ? '0 : quo[5];
  assign out_ch.out_r2c0    = sing_r[DIV_STAGES-1] ? '0 : quo[6];
  assign out_ch.out_r2c1    = sing_r[DIV_STAGES-1] ? '0 : quo[7];
  assign out_ch.out_r2c2    = sing_r[DIV_STAGES-1] ? '0 : quo[8];
  assign out_ch.determinant = sing_r[DIV_STAGES-1] ? '0 : dval_r[DIV_STAGES-1];
  assign out_ch.saturated   = !sing_r[DIV_STAGES-1] &&
                              ((|clip) || dclip_r[DIV_STAGES-1]);

  // a zero determinant can never round to a clipped determinant field
  a_sing_no_dclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |-> !dclip_r[DIV_STAGES-1])
    else $error("singular transaction with clipped determinant");

  // a held pipeline keeps every valid bit in place
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved during a stall");

  // stage 6 zero flag agrees with the magnitude it travels with
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (dzero_r == (dmag_r == '0)))
    else $error("determinant zero flag out of step with magnitude");

endmodule

### tb/tb_matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
// tb_matrix3x3_inverse_core: self-checking bench for the 3x3 fixed point inverse core
// depends on mi3_in_if, mi3_out_if and matrix3x3_inverse_core from the rtl folder
// an exact wide-integer predictor runs beside the core and every result is checked
module tb_matrix3x3_inverse_core;

  localparam int unsigned EW       = 32;
  localparam int unsigned FB       = 16;
  localparam int unsigned LATENCY  = EW + 8;
  localparam int unsigned N_RANDOM = 1140;

  // wide enough for the exact determinant and the shifted adjugate numerators
  typedef logic signed [191:0] wide_t;

  // one matrix, row-major, index 0 is row 0 column 0
  typedef logic [8:0][EW-1:0] matrix_t;

  typedef struct packed {
    logic [8:0][EW-1:0] inv;
    logic [EW-1:0]      det;
    logic               singular;
    logic               saturated;
  } inverse_t;

  logic clk;
  logic rst_n;

  mi3_in_if  #(.ELEMENT_WIDTH(EW)) in_ch ();
  mi3_out_if #(.ELEMENT_WIDTH(EW)) out_ch ();

  matrix3x3_inverse_core #(
    .ELEMENT_WIDTH(EW),
    .FRACTION_BITS(FB)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // expected inverses, oldest first
  inverse_t pending_inverses[$];
  int       error_count;

  // sender pacing: percentage chance of a gap after each burst, gap and burst lengths
  int gap_pct;
  int gap_max;
  int burst_left;

  // receiver pacing: percentage of cycles stalled, plus a requested long hold-off
  int  stall_pct;
  bit  hold_req;
  int  hold_cycles;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // operand table of each adjugate entry: a*b - c*d
  function automatic int minor_operand(int entry, int k);
    int ops[9][4];
    ops = '{'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
            '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
            '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
    return ops[entry][k];
  endfunction

  function automatic wide_t mag(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic wide_t div_round(wide_t n, wide_t d);
    wide_t un, ud, q, r;
    un = mag(n);
    ud = mag(d);
    q  = un / ud;
    r  = un % ud;
    if ((r <<< 1) >= ud) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // arithmetic shift right rounded to nearest, ties away from zero
  function automatic wide_t shr_round(wide_t v, int s);
    wide_t m, half;
    half = 1;
    half = half <<< (s - 1);
    m = (mag(v) + half) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [EW-1:0] clip(wide_t v, ref logic clipped);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (EW - 1)) - 1;
    lo = -(wide_t'(1) <<< (EW - 1));
    if (v > hi) begin
      clipped = 1'b1;
      v = hi;
    end else if (v < lo) begin
      clipped = 1'b1;
      v = lo;
    end
    return v[EW-1:0];
  endfunction

  function automatic inverse_t predict_inverse(matrix_t m);
    wide_t    e[9];
    wide_t    adj[9];
    wide_t    det;
    inverse_t r;
    logic     clipped;
    clipped = 1'b0;
    r = '0;
    for (int i = 0; i < 9; i++) e[i] = $signed(m[i]);
    for (int i = 0; i < 9; i++)
      adj[i] = e[minor_operand(i, 0)] * e[minor_operand(i, 1)]
             - e[minor_operand(i, 2)] * e[minor_operand(i, 3)];
    // cofactor expansion along the first row
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++)
      r.inv[i] = clip(div_round(adj[i] <<< (2 * FB), det), clipped);
    r.det       = clip(shr_round(det, 2 * FB), clipped);
    r.saturated = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one matrix per call, valid stays high across a burst
  // entered and left just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_matrix(matrix_t m);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 99) < gap_pct) begin
        gap = $urandom_range(1, gap_max);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.in_r0c0 <= m[0];
    in_ch.in_r0c1 <= m[1];
    in_ch.in_r0c2 <= m[2];
    in_ch.in_r1c0 <= m[3];
    in_ch.in_r1c1 <= m[4];
    in_ch.in_r1c2 <= m[5];
    in_ch.in_r2c0 <= m[6];
    in_ch.in_r2c1 <= m[7];
    in_ch.in_r2c2 <= m[8];
    do @(posedge clk); while (!in_ch.ready);
    pending_inverses.push_back(predict_inverse(m));
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_inverses.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a long hold-off when asked
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 400) begin
        hold_req    = 1'b0;
        hold_cycles = 0;
      end
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    inverse_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.inv[0]    = out_ch.out_r0c0;
      got.inv[1]    = out_ch.out_r0c1;
      got.inv[2]    = out_ch.out_r0c2;
      got.inv[3]    = out_ch.out_r1c0;
      got.inv[4]    = out_ch.out_r1c1;
      got.inv[5]    = out_ch.out_r1c2;
      got.inv[6]    = out_ch.out_r2c0;
      got.inv[7]    = out_ch.out_r2c1;
      got.inv[8]    = out_ch.out_r2c2;
      got.det       = out_ch.determinant;
      got.singular  = out_ch.singular;
      got.saturated = out_ch.saturated;
      if (pending_inverses.size() == 0) begin
        $error("result transaction with no matrix outstanding");
        error_count++;
      end else begin
        want = pending_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.inv[i] !== want.inv[i]) begin
            $error("out_r%0dc%0d: expected %h, got %h", i / 3, i % 3, want.inv[i], got.inv[i]);
            error_count++;
          end
        if (got.det !== want.det) begin
          $error("determinant: expected %h, got %h", want.det, got.det);
          error_count++;
        end
        if (got.singular !== want.singular) begin
          $error("singular: expected %b, got %b", want.singular, got.singular);
          error_count++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, got.saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic matrix_t diag_matrix(logic [EW-1:0] a, logic [EW-1:0] b,
                                          logic [EW-1:0] c);
    matrix_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  function automatic logic [EW-1:0] rand_element(int kind);
    int v;
    case (kind)
      0: begin
        // within about plus or minus four
        v = int'($urandom_range(0, 524287)) - 262144;
        return v;
      end
      1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      default: begin
        // small integers, exact in Q16.16
        v = int'($urandom_range(0, 14)) - 7;
        return v <<< FB;
      end
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    int      kind;
    int      pick;
    pick = $urandom_range(0, 9);
    kind = (pick < 4) ? 0 : (pick < 6) ? 1 : (pick == 6) ? 2 : 3;
    for (int i = 0; i < 9; i++)
      m[i] = ($urandom_range(0, 9) == 0) ? rand_element($urandom_range(0, 3))
                                         : rand_element(kind);
    // now and then a linearly dependent row or a zero column
    if ($urandom_range(0, 11) == 0) begin
      for (int c = 0; c < 3; c++) m[6 + c] = m[c];
    end else if ($urandom_range(0, 11) == 0) begin
      for (int r = 0; r < 3; r++) m[3 * r + 1] = '0;
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // identity, zero, field extremes and scaled diagonals
  task automatic test_extremes();
    matrix_t m;
    send_matrix(diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix('0);
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag_matrix(32'h0002_0000, 32'hfffe_0000, 32'h0000_8000));
    send_matrix(diag_matrix(32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
    // anti-diagonal permutation
    m = '0;
    m[2] = 32'h0001_0000;
    m[4] = 32'h0001_0000;
    m[6] = 32'h0001_0000;
    send_matrix(m);
    // one extreme element in each place, so each adjugate path sees it
    for (int i = 0; i < 9; i++) begin
      m = diag_matrix(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_matrix(m);
    end
  endtask

  // exactly zero determinant: all-zero inverse and the singular flag
  task automatic test_singular();
    matrix_t m;
    m = '0;
    for (int i = 0; i < 9; i++) m[i] = (i + 1) <<< FB;
    send_matrix(m);
    m = '0;
    m[0] = 32'h7fff_ffff;
    m[1] = 32'h8000_0000;
    m[3] = 32'h7fff_ffff;
    m[4] = 32'h8000_0000;
    m[8] = 32'h0001_0000;
    send_matrix(m);
  endtask

  // tiny nonzero determinants, the first two rounding to zero: singular stays low, their inverses saturate
  task automatic test_tiny_determinant();
    send_matrix(diag_matrix(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag_matrix(32'hffff_ffff, 32'h0000_0001, 32'h0000_0001));
    send_matrix(diag_matrix(32'h0000_0100, 32'h0000_0100, 32'h0001_0000));
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      // change the pacing every so often, sometimes to no idling at all
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 30; stall_pct = 20; gap_max = 5; end
          2: begin gap_pct = 70; stall_pct = 60; gap_max = 12; end
          default: begin gap_pct = 10; stall_pct = 40; gap_max = 3; end
        endcase
      end
      send_matrix(rand_matrix());
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    hold_req = 1'b1;
    gap_pct  = 0;
    for (int n = 0; n < 120; n++) send_matrix(rand_matrix());
  endtask

  // sender waits until every outstanding matrix has come back, then resumes
  task automatic test_drain_pause();
    idle_sender();
    wait_drained();
    for (int n = 0; n < 20; n++) send_matrix(rand_matrix());
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    gap_pct       = 20;
    gap_max       = 4;
    burst_left    = 0;
    stall_pct     = 25;
    hold_req      = 1'b0;
    hold_cycles   = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_r0c0 = '0;
    in_ch.in_r0c1 = '0;
    in_ch.in_r0c2 = '0;
    in_ch.in_r1c0 = '0;
    in_ch.in_r1c1 = '0;
    in_ch.in_r1c2 = '0;
    in_ch.in_r2c0 = '0;
    in_ch.in_r2c1 = '0;
    in_ch.in_r2c2 = '0;
    out_ch.ready  = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_extremes();
    test_singular();
    test_tiny_determinant();
    test_backpressure();
    test_drain_pause();
    test_random(N_RANDOM);
    idle_sender();

    // drain, then allow a pipeline depth for any stray result
    wait_drained();
    repeat (LATENCY + 20) @(negedge clk);
    if (pending_inverses.size() != 0) begin
      $error("%0d expected results never arrived", pending_inverses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
